>>> sv/btlpm_pkg.sv
// Shared types, constants and helpers of the binary trie prefix match engine.
package btlpm_pkg;

   localparam int NODES     = 4096;
   localparam int NODE_W    = $clog2(NODES);
   localparam int FREE_W    = NODE_W + 1;
   localparam int ADDR_BITS = 32;
   localparam int LEVEL_W   = $clog2(ADDR_BITS + 1);
   localparam int BIT_W     = $clog2(ADDR_BITS);
   localparam int KEY_W     = 128;
   localparam int COUNT_W   = 32;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_HIT  = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic              keyed;
      logic [NODE_W-1:0] zero;
      logic [NODE_W-1:0] one;
   } node_rec_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      node_rec_type      rec;
      logic              key_en;
      logic [KEY_W-1:0]  key;
   } node_wr_type;

   typedef struct packed {
      logic              pop;
      logic              push;
      logic [NODE_W-1:0] push_node;
      logic              clr;
      logic [NODE_W-1:0] clr_idx;
   } free_ctl_type;

   // Address bit taken at a given trie level, most significant bit first.
   function automatic logic addr_bit(input logic [ADDR_BITS-1:0] addr,
                                     input logic [LEVEL_W-1:0] level);
      logic [LEVEL_W-1:0] pos;
      pos = LEVEL_W'(ADDR_BITS - 1) - level;
      return addr[pos[BIT_W-1:0]];
   endfunction

endpackage

>>> sv/btlpm_node_store.sv
// Node pool storage: child links, key flag and key per node.
module btlpm_node_store (
   input  logic                                   clock,
   input  logic                                   rd_en,
   input  logic [btlpm_pkg::NODE_W-1:0]           rd_addr,
   output btlpm_pkg::node_rec_type                rd_rec,
   output logic [btlpm_pkg::KEY_W-1:0]            rd_key,
   input  btlpm_pkg::node_wr_type                 wr
);

   btlpm_pkg::node_rec_type         rec_mem [btlpm_pkg::NODES];
   logic [btlpm_pkg::KEY_W-1:0]     key_mem [btlpm_pkg::NODES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rec_mem[wr.addr] <= wr.rec;
      end
      if (wr.key_en) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (rd_en) begin
         rd_rec <= rec_mem[rd_addr];
         rd_key <= key_mem[rd_addr];
      end
   end

endmodule

>>> sv/btlpm_free_list.sv
// Free node stack with its fill count.
module btlpm_free_list (
   input  logic                            clock,
   input  logic                            reset,
   input  btlpm_pkg::free_ctl_type         ctl,
   output logic [btlpm_pkg::NODE_W-1:0]    pop_node,
   output logic [btlpm_pkg::FREE_W-1:0]    total
);

   logic [btlpm_pkg::NODE_W-1:0] stack_mem [btlpm_pkg::NODES];
   logic [btlpm_pkg::FREE_W-1:0] total_ff;
   logic [btlpm_pkg::FREE_W-1:0] total_in;
   logic [btlpm_pkg::FREE_W-1:0] top_idx;

   assign total   = total_ff;
   assign top_idx = total_ff - 1'b1;

   always_comb begin
      total_in = total_ff;
      if (ctl.pop) begin
         total_in = total_ff - 1'b1;
      end else if (ctl.push && total_ff < btlpm_pkg::FREE_W'(btlpm_pkg::NODES)) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= btlpm_pkg::FREE_W'(btlpm_pkg::NODES - 1);
      end else begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clr) begin
         stack_mem[ctl.clr_idx] <= btlpm_pkg::NODE_W'(btlpm_pkg::NODES - 1) - ctl.clr_idx;
      end else if (ctl.push && total_ff < btlpm_pkg::FREE_W'(btlpm_pkg::NODES)) begin
         stack_mem[total_ff[btlpm_pkg::NODE_W-1:0]] <= ctl.push_node;
      end
      if (ctl.pop) begin
         pop_node <= stack_mem[top_idx[btlpm_pkg::NODE_W-1:0]];
      end
   end

endmodule

>>> sv/binary_trie_lpm_engine.sv
// Top level of the binary trie longest prefix match engine and its sequencer.

// IPv4 longest prefix match over a one-bit-per-level binary trie of 4096 nodes.
// Each request item carries a command in req_tuser (lookup, insert, delete) and
// produces exactly one response item. After reset the engine runs a clearing
// pass over the node pool and free list, during which no item is accepted. A
// single node memory read port is shared by every step. A lookup walks up to 33
// levels. An insert walks the existing levels, then for each created node pops it
// from the free stack (S_POP), links it under the current node (S_LINK) and clears
// it (S_INIT), and ends with S_SETKEY and S_DONE. A delete walks down to the prefix
// level and clears its key, then for each pruned node returns it to the free stack
// (S_PRUNE) and clears the parent link (S_PFIX), and ends through S_PRUNE and S_DONE.
// The engine is ready for the next item in the same cycle that the response becomes valid.
// The engine works on one item at a time; the response register lets the next
// item be accepted while the previous response is still waiting. Unused command
// code 3 returns a miss.
module binary_trie_lpm_engine (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // address[31:0], prefix_len[37:32], key_high[101:38], key_low[165:102], zero pad
   input  logic [167:0]   req_tdata,
   // command[1:0]
   input  logic [1:0]     req_tuser,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // match_high[63:0], match_low[127:64], stored_count[159:128]
   output logic [159:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]     rsp_tuser
);

   localparam int NW = btlpm_pkg::NODE_W;
   localparam int LW = btlpm_pkg::LEVEL_W;
   localparam int BW = btlpm_pkg::BIT_W;
   localparam int KW = btlpm_pkg::KEY_W;
   localparam int CW = btlpm_pkg::COUNT_W;
   localparam int AB = btlpm_pkg::ADDR_BITS;

   typedef enum logic [9:0] {
      S_CLEAR  = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_WALK   = 10'b0000000100,
      S_POP    = 10'b0000001000,
      S_LINK   = 10'b0000010000,
      S_INIT   = 10'b0000100000,
      S_SETKEY = 10'b0001000000,
      S_PRUNE  = 10'b0010000000,
      S_PFIX   = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [AB-1:0]           addr_ff, addr_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [KW-1:0]           key_ff, key_in;
   logic [NW-1:0]           node_ff, node_in;
   logic [LW-1:0]           depth_ff, depth_in;
   btlpm_pkg::node_rec_type rec_ff, rec_in;
   logic                    hit_ff, hit_in;
   logic [KW-1:0]           match_ff, match_in;
   logic [1:0]              status_ff, status_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [NW-1:0]           clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [159:0]            rsp_data_ff, rsp_data_in;
   logic [1:0]              rsp_user_ff, rsp_user_in;

   // Node numbers along the current delete path, one per level above the end node.
   logic [NW-1:0]           path_ff [AB];
   logic                    path_we;

   logic                    rd_en;
   logic [NW-1:0]           rd_addr;
   btlpm_pkg::node_rec_type rd_rec;
   logic [KW-1:0]           rd_key;
   btlpm_pkg::node_wr_type  wr;
   btlpm_pkg::free_ctl_type fctl;
   logic [NW-1:0]           pop_node;
   logic [btlpm_pkg::FREE_W-1:0] free_total;

   logic                    cur_bit;
   logic [NW-1:0]           child;
   logic [LW-1:0]           req_len;
   logic [LW-1:0]           up_level;
   logic                    up_bit;

   btlpm_node_store u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec),
      .rd_key  (rd_key),
      .wr      (wr)
   );

   btlpm_free_list u_free (
      .clock    (clock),
      .reset    (reset),
      .ctl      (fctl),
      .pop_node (pop_node),
      .total    (free_total)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Prefix lengths beyond the address width act as a full-length prefix.
   assign req_len  = (req_tdata[37:32] > LW'(AB)) ? LW'(AB) : req_tdata[37:32];
   assign cur_bit  = (depth_ff < LW'(AB)) ? btlpm_pkg::addr_bit(addr_ff, depth_ff) : 1'b0;
   assign child    = cur_bit ? rd_rec.one : rd_rec.zero;
   assign up_level = depth_ff - 1'b1;
   assign up_bit   = btlpm_pkg::addr_bit(addr_ff, up_level);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      key_in       = key_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      rec_in       = rec_ff;
      hit_in       = hit_ff;
      match_in     = match_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;
      path_we      = 1'b0;
      wr           = '0;
      wr.addr      = node_ff;
      wr.key       = key_ff;
      fctl         = '0;
      fctl.clr_idx = clr_ff;
      fctl.push_node = node_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // Empty every node record and refill the free stack, one entry a cycle.
            wr.en    = 1'b1;
            wr.addr  = clr_ff;
            wr.rec   = '0;
            fctl.clr = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == NW'(btlpm_pkg::NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               addr_in  = req_tdata[31:0];
               len_in   = req_len;
               key_in   = {req_tdata[101:38], req_tdata[165:102]};
               node_in  = '0;
               depth_in = '0;
               hit_in   = 1'b0;
               match_in = '0;
               if (req_tuser == btlpm_pkg::CMD_LOOKUP || req_tuser == btlpm_pkg::CMD_INSERT ||
                   req_tuser == btlpm_pkg::CMD_DELETE) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_WALK;
               end else begin
                  status_in = btlpm_pkg::ST_MISS;
                  state_in  = S_DONE;
               end
            end
         end
         S_WALK: begin
            case (cmd_ff)
               btlpm_pkg::CMD_LOOKUP: begin
                  if (rd_rec.keyed) begin
                     hit_in   = 1'b1;
                     match_in = rd_key;
                  end
                  if (depth_ff == LW'(AB) || child == '0) begin
                     status_in = (hit_ff || rd_rec.keyed) ? btlpm_pkg::ST_HIT
                                                          : btlpm_pkg::ST_MISS;
                     state_in  = S_DONE;
                  end else begin
                     node_in  = child;
                     depth_in = depth_ff + 1'b1;
                     rd_en    = 1'b1;
                     rd_addr  = child;
                  end
               end
               btlpm_pkg::CMD_INSERT: begin
                  rec_in = rd_rec;
                  if (depth_ff == len_ff) begin
                     state_in = S_SETKEY;
                  end else if (child == '0) begin
                     if (btlpm_pkg::FREE_W'(len_ff - depth_ff) > free_total) begin
                        status_in = btlpm_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_POP;
                     end
                  end else begin
                     node_in  = child;
                     depth_in = depth_ff + 1'b1;
                     rd_en    = 1'b1;
                     rd_addr  = child;
                  end
               end
               default: begin
                  path_we = 1'b1;
                  if (depth_ff == len_ff) begin
                     if (rd_rec.keyed) begin
                        rec_in       = rd_rec;
                        rec_in.keyed = 1'b0;
                        wr.en        = 1'b1;
                        wr.rec       = rec_in;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                        status_in = btlpm_pkg::ST_HIT;
                        state_in  = S_PRUNE;
                     end else begin
                        status_in = btlpm_pkg::ST_MISS;
                        state_in  = S_DONE;
                     end
                  end else if (child == '0) begin
                     status_in = btlpm_pkg::ST_MISS;
                     state_in  = S_DONE;
                  end else begin
                     node_in  = child;
                     depth_in = depth_ff + 1'b1;
                     rd_en    = 1'b1;
                     rd_addr  = child;
                  end
               end
            endcase
         end
         S_POP: begin
            fctl.pop = 1'b1;
            state_in = S_LINK;
         end
         S_LINK: begin
            // Hang the fresh node under the current one.
            wr.en  = 1'b1;
            wr.rec = rec_ff;
            if (cur_bit) begin
               wr.rec.one = pop_node;
            end else begin
               wr.rec.zero = pop_node;
            end
            node_in  = pop_node;
            depth_in = depth_ff + 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            wr.en    = 1'b1;
            wr.rec   = '0;
            rec_in   = '0;
            state_in = (depth_ff == len_ff) ? S_SETKEY : S_POP;
         end
         S_SETKEY: begin
            wr.en        = 1'b1;
            wr.rec       = rec_ff;
            wr.rec.keyed = 1'b1;
            wr.key_en    = 1'b1;
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            status_in = btlpm_pkg::ST_HIT;
            state_in  = S_DONE;
         end
         S_PRUNE: begin
            // Give back the node if it became empty, then fix its parent.
            if (depth_ff == '0 || rec_ff.keyed || rec_ff.zero != '0 || rec_ff.one != '0) begin
               state_in = S_DONE;
            end else begin
               fctl.push = 1'b1;
               rd_en     = 1'b1;
               rd_addr   = path_ff[up_level[BW-1:0]];
               node_in   = path_ff[up_level[BW-1:0]];
               state_in  = S_PFIX;
            end
         end
         S_PFIX: begin
            rec_in = rd_rec;
            if (up_bit) begin
               rec_in.one = '0;
            end else begin
               rec_in.zero = '0;
            end
            wr.en    = 1'b1;
            wr.rec   = rec_in;
            depth_in = up_level;
            state_in = S_PRUNE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {count_ff, match_ff[KW/2-1:0], match_ff[KW-1:KW/2]};
               if (!(cmd_ff == btlpm_pkg::CMD_LOOKUP && status_ff == btlpm_pkg::ST_HIT)) begin
                  rsp_data_in[KW-1:0] = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      len_ff      <= len_in;
      key_ff      <= key_in;
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      rec_ff      <= rec_in;
      hit_ff      <= hit_in;
      match_ff    <= match_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (path_we && depth_ff < LW'(AB)) begin
         path_ff[depth_ff[BW-1:0]] <= node_ff;
      end
   end

endmodule
